// ----- design/midc_pkg.sv -----
// Package for the message identifier dedup cache.
// Types, sequencer states and fixed constants; no dependencies.
package midc_pkg;

    localparam int ID_W   = 32;
    localparam int TIME_W = 32;
    localparam int AGE_W  = 23;

    localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd3600000;

    // floor(x / 1000) = (x * DIV_RECIP) >> DIV_SHIFT, exact for any 32-bit x
    localparam int              RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd274877907;
    localparam int              DIV_SHIFT = 38;
    localparam int              PROD_W    = TIME_W + RECIP_W;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCALE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } ring_wr_t;

endpackage

// ----- design/midc_ring.sv -----
// Entry ring: identifier/time memory, write pointer and fill count.
// Depends on midc_pkg. Registered read, one write per cycle.
module midc_ring #(
    parameter int ENTRIES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  midc_pkg::ring_wr_t           wr,
    input  logic                         rd_en,
    input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
    output midc_pkg::entry_t             rd_data,
    output logic [$clog2(ENTRIES+1)-1:0] fill
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    midc_pkg::entry_t mem [ENTRIES];
    midc_pkg::entry_t rd_data_reg;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    fill_next;

    // entries at or above the fill count were never written and hold no set value;
    // the lookup scan reads only entries below the fill count
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (wr.en)
        begin
            wp_next = (wp_reg == AW'(ENTRIES - 1)) ? '0 : wp_reg + AW'(1);
            if (fill_reg != CW'(ENTRIES))
            begin
                fill_next = fill_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wp_reg] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

// ----- design/message_id_dedup_cache.sv -----
// Message identifier dedup cache, top level: stream ports, sequencer, scaler.
// Depends on midc_pkg and midc_ring.
//
//  channel   | signals                                  | role
//  s_axis    | tvalid tready tdata[63:0] tuser[0:0]     | insert / lookup items in
//  m_axis    | tvalid tready tdata[23:0]                | one result item per input
//  cfg       | cfg_valid cfg_ready cfg_data[31:0]       | max_age_ms write
//
// Insert and lookup of id 0 skip the scan. Other lookups scan up to fill
// entries, one ring entry compared per cycle through the single read port,
// fill being the entries written since reset (at most CACHE_ENTRIES).
// Reset clears pointer and fill count at once; no clearing pass.
// The next item is taken while a result waits on m_axis; a stalled m_axis
// holds the sequencer only once its own result is ready.
module message_id_dedup_cache #(
    parameter int CACHE_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // msg_id[31:0], now_ms[63:32]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // is_duplicate[0], age_sec[23:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    midc_pkg::state_t state_reg;
    midc_pkg::state_t state_next;

    logic [midc_pkg::TIME_W-1:0] max_age_reg;
    logic [midc_pkg::ID_W-1:0]   key_id_reg;
    logic [midc_pkg::ID_W-1:0]   key_id_next;
    logic [midc_pkg::TIME_W-1:0] now_reg;
    logic [midc_pkg::TIME_W-1:0] now_next;
    logic [CW-1:0]               scan_idx_reg;
    logic [CW-1:0]               scan_idx_next;
    logic                        pend_reg;
    logic                        pend_next;
    logic [midc_pkg::TIME_W-1:0] age_reg;
    logic [midc_pkg::TIME_W-1:0] age_next;
    logic                        res_dup_reg;
    logic                        res_dup_next;
    logic [midc_pkg::PROD_W-1:0] prod_reg;
    logic [midc_pkg::PROD_W-1:0] prod_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_dup_reg;
    logic                        out_dup_next;
    logic [midc_pkg::AGE_W-1:0]  out_age_reg;
    logic [midc_pkg::AGE_W-1:0]  out_age_next;

    logic                        in_fire;
    logic                        in_op;
    logic [midc_pkg::ID_W-1:0]   in_id;
    logic [midc_pkg::TIME_W-1:0] in_now;
    logic                        issue;
    logic                        hit;
    logic                        out_free;
    logic [midc_pkg::TIME_W-1:0] cmp_age;

    midc_pkg::ring_wr_t ring_wr;
    midc_pkg::entry_t   rd_data;
    logic [CW-1:0]      fill;

    midc_ring #(
        .ENTRIES (CACHE_ENTRIES)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ring_wr),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_data),
        .fill    (fill)
    );

    assign in_op  = s_axis_tuser[0];
    assign in_id  = s_axis_tdata[31:0];
    assign in_now = s_axis_tdata[63:32];

    assign s_axis_tready = (state_reg == midc_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign ring_wr.en         = in_fire && (in_op == midc_pkg::OP_INSERT);
    assign ring_wr.data.id    = in_id;
    assign ring_wr.data.stamp = in_now;

    assign issue    = (state_reg == midc_pkg::ST_SCAN) && (scan_idx_reg < fill);
    assign cmp_age  = now_reg - rd_data.stamp;
    assign hit      = pend_reg && (rd_data.id == key_id_reg) && (cmp_age < max_age_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            midc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == midc_pkg::OP_LOOKUP && in_id != '0)
                    begin
                        state_next = midc_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = midc_pkg::ST_RESULT;
                    end
                end
            end
            midc_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = midc_pkg::ST_SCALE;
                end
                else if (!issue && !pend_reg)
                begin
                    state_next = midc_pkg::ST_RESULT;
                end
            end
            midc_pkg::ST_SCALE:
            begin
                state_next = midc_pkg::ST_RESULT;
            end
            midc_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = midc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = midc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_id_next    = key_id_reg;
        now_next       = now_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        age_next       = age_reg;
        res_dup_next   = res_dup_reg;
        prod_next      = prod_reg;
        out_dup_next   = out_dup_reg;
        out_age_next   = out_age_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            midc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_id_next   = in_id;
                    now_next      = in_now;
                    scan_idx_next = '0;
                    res_dup_next  = 1'b0;
                end
            end
            midc_pkg::ST_SCAN:
            begin
                pend_next = issue && !hit;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    res_dup_next = 1'b1;
                    age_next     = cmp_age;
                end
            end
            midc_pkg::ST_SCALE:
            begin
                prod_next = midc_pkg::PROD_W'(age_reg) * midc_pkg::PROD_W'(midc_pkg::DIV_RECIP);
            end
            midc_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dup_next   = res_dup_reg;
                    out_age_next   = res_dup_reg
                                   ? prod_reg[midc_pkg::DIV_SHIFT +: midc_pkg::AGE_W]
                                   : '0;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= midc_pkg::ST_IDLE;
            max_age_reg   <= midc_pkg::MAX_AGE_RESET;
            pend_reg      <= 1'b0;
            res_dup_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            res_dup_reg   <= res_dup_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_age_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_id_reg   <= key_id_next;
        now_reg      <= now_next;
        scan_idx_reg <= scan_idx_next;
        age_reg      <= age_next;
        prod_reg     <= prod_next;
        out_dup_reg  <= out_dup_next;
        out_age_reg  <= out_age_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_age_reg, out_dup_reg};

endmodule

// ----- design/midc_checker.sv -----
// Port-level checks for the message identifier dedup cache.
// Depends on message_id_dedup_cache; attached by the bind below.
module midc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [31:0] cfg_data
);

    // one item at a time: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on the cycle after an accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    a_no_dup_zero_age: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[23:1] == 23'd0)
        else $error("age set on a non-duplicate result");

    a_age_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[23:1] <= 23'd4294967)
        else $error("age in seconds out of range");

endmodule

bind message_id_dedup_cache midc_checker u_midc_checker (.*);

// ----- sim/message_id_dedup_cache_tb.sv -----
// Testbench for message_id_dedup_cache: drives insert and lookup items, paces both streams
// at random and checks every result item against a scoreboard that predicts them.
// Depends on midc_pkg and the design sources only.
module message_id_dedup_cache_tb;

    // small ring so that wrap-around and overwrites are reached quickly
    localparam int                          RING_DEPTH     = 16;
    localparam logic [midc_pkg::TIME_W-1:0] MS_PER_SEC     = 32'd1000;
    localparam int                          WATCHDOG_LIMIT = 2000;
    localparam int                          ID_POOL        = 6;

    typedef struct packed {
        logic                       dup;
        logic [midc_pkg::AGE_W-1:0] age_sec;
    } verdict_t;

    class dedup_scoreboard;
        logic [midc_pkg::ID_W-1:0]   ids    [RING_DEPTH];
        logic [midc_pkg::TIME_W-1:0] stamps [RING_DEPTH];
        int                          wr_ptr;
        logic [midc_pkg::TIME_W-1:0] max_age;
        verdict_t                    awaited [$];
        int                          n_fail;
        int                          n_inserts;
        int                          n_lookups;
        int                          n_dups;
        int                          n_results;
        int                          n_settings;

        function new();
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ids[i]    = '0;
                stamps[i] = '0;
            end
            wr_ptr     = 0;
            max_age    = midc_pkg::MAX_AGE_RESET;
            n_fail     = 0;
            n_inserts  = 0;
            n_lookups  = 0;
            n_dups     = 0;
            n_results  = 0;
            n_settings = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_max_age(logic [midc_pkg::TIME_W-1:0] value);
            max_age = value;
            n_settings++;
        endfunction

        // accepted input item: update ring copy, queue the verdict it must give
        function void note_item(logic op, logic [midc_pkg::ID_W-1:0] id,
                                logic [midc_pkg::TIME_W-1:0] stamp_now);
            verdict_t                    v;
            logic [midc_pkg::TIME_W-1:0] age;
            v = '0;
            if (op == midc_pkg::OP_INSERT)
            begin
                n_inserts++;
                ids[wr_ptr]    = id;
                stamps[wr_ptr] = stamp_now;
                wr_ptr         = (wr_ptr + 1) % RING_DEPTH;
            end
            else
            begin
                n_lookups++;
                if (id != '0)
                begin
                    for (int i = 0; i < RING_DEPTH; i++)
                    begin
                        age = stamp_now - stamps[i];
                        if (ids[i] == id && age < max_age)
                        begin
                            v.dup     = 1'b1;
                            v.age_sec = midc_pkg::AGE_W'(age / MS_PER_SEC);
                            break;
                        end
                    end
                end
                if (v.dup)
                    n_dups++;
            end
            awaited.push_back(v);
        endfunction

        task report(string what);
            n_fail++;
            $display("MISMATCH: %s", what);
        endtask

        task check_result(verdict_t got);
            verdict_t want;
            n_results++;
            if (awaited.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing awaited", n_results));
                return;
            end
            want = awaited.pop_front();
            if (got.dup !== want.dup)
                report($sformatf("result %0d is_duplicate got %0d, expected %0d",
                                 n_results, got.dup, want.dup));
            if (got.age_sec !== want.age_sec)
                report($sformatf("result %0d age_sec got %0d, expected %0d",
                                 n_results, got.age_sec, want.age_sec));
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;

    dedup_scoreboard             sb;
    bit                          stall_free = 1'b1;
    int                          idle_run   = 0;
    logic [midc_pkg::TIME_W-1:0] t_now      = '0;

    message_id_dedup_cache #(
        .CACHE_ENTRIES (RING_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // msg_id[31:0], now_ms[63:32]
        .s_axis_tuser  (s_axis_tuser),   // op[0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // is_duplicate[0], age_sec[23:1]
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task send_item(logic op, logic [midc_pkg::ID_W-1:0] id,
                   logic [midc_pkg::TIME_W-1:0] stamp_now);
        int gap;
        gap = (stall_free || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp_now, id};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(op, id, stamp_now);
    endtask

    // stop sending and wait until every awaited result has come back
    task settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task write_max_age(logic [midc_pkg::TIME_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_max_age(value);
    endtask

    task random_phase(int n_items, logic [midc_pkg::TIME_W-1:0] age_limit, bit calm);
        logic [midc_pkg::ID_W-1:0]   pool [ID_POOL];
        logic [midc_pkg::ID_W-1:0]   id;
        logic [midc_pkg::TIME_W-1:0] step_lim;
        logic                        op;
        int                          r;
        write_max_age(age_limit);
        stall_free = calm;
        step_lim   = (age_limit > 3) ? age_limit / 3 : 32'd1;
        for (int i = 0; i < ID_POOL; i++)
            pool[i] = $urandom();
        for (int k = 0; k < n_items; k++)
        begin
            op = ($urandom_range(0, 99) < 45) ? midc_pkg::OP_INSERT : midc_pkg::OP_LOOKUP;
            r  = $urandom_range(0, 99);
            if (op == midc_pkg::OP_INSERT)
                id = (r < 90) ? pool[$urandom_range(0, ID_POOL - 1)] : $urandom();
            else if (r < 75)
                id = pool[$urandom_range(0, ID_POOL - 1)];
            else if (r < 90)
                id = $urandom();
            else
                id = '0;
            r = $urandom_range(0, 99);
            if (r < 70)
                t_now = t_now + $urandom_range(0, step_lim);
            else if (r < 95 && r >= 85)
                t_now = t_now - $urandom_range(0, step_lim);
            else if (r >= 95)
                t_now = $urandom();
            send_item(op, id, t_now);
        end
    endtask

    initial
    begin : sink_pacing
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (stall_free)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 9) < 6)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(verdict_t'{dup: m_axis_tdata[0], age_sec: m_axis_tdata[23:1]});
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_run < WATCHDOG_LIMIT) @(posedge clk);
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero id, empty ring, extremes, age boundary, stale entries, time wrap
        stall_free = 1'b1;
        send_item(midc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(midc_pkg::OP_INSERT, 32'h0000_0000, 32'd100);
        send_item(midc_pkg::OP_LOOKUP, 32'h0000_0000, 32'd100);
        send_item(midc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd3599998);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd3599999);
        send_item(midc_pkg::OP_INSERT, 32'hA5A5_5A5A, 32'd1000);
        send_item(midc_pkg::OP_INSERT, 32'hA5A5_5A5A, 32'd5000);
        send_item(midc_pkg::OP_LOOKUP, 32'hA5A5_5A5A, 32'd3601500);
        send_item(midc_pkg::OP_LOOKUP, 32'hA5A5_5A5A, 32'd3000);
        send_item(midc_pkg::OP_INSERT, 32'h1234_5678, 32'h8000_0000);
        send_item(midc_pkg::OP_LOOKUP, 32'h1234_5678, 32'h7FFF_FFFF);
        write_max_age(32'hFFFF_FFFF);
        send_item(midc_pkg::OP_LOOKUP, 32'h1234_5678, 32'h7FFF_FFFF);
        send_item(midc_pkg::OP_LOOKUP, 32'h1234_5678, 32'h7FFF_FFFE);
        write_max_age(32'h0000_0000);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(midc_pkg::OP_LOOKUP, 32'hA5A5_5A5A, 32'd3000);
        write_max_age(32'h0000_0001);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(midc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

        t_now = $urandom();
        random_phase(20, midc_pkg::MAX_AGE_RESET, 1'b1);
        random_phase(20, 32'd1500, 1'b0);
        random_phase(20, $urandom() | 32'h1, 1'b0);
        random_phase(20, 32'hFFFF_FFFF, 1'b0);
        random_phase(20, 32'h0000_0001, 1'b0);
        random_phase(20, $urandom_range(1000, 200000), 1'b0);

        settle();
        repeat (RING_DEPTH + 8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Covered %0d inserts and %0d lookups (%0d duplicates) over %0d max-age settings",
                 sb.n_inserts, sb.n_lookups, sb.n_dups, sb.n_settings);
        $display("Ring of %0d entries refilled about %0d times; both streams paced at random",
                 RING_DEPTH, sb.n_inserts / RING_DEPTH);
        if (sb.n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/midc_pkg.sv
design/midc_ring.sv
design/message_id_dedup_cache.sv
design/midc_checker.sv
sim/message_id_dedup_cache_tb.sv
